@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker files of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/idw_pkg.sv @@
// Types and constants for the I2C display write framer.
// No dependencies; imported by idw_in_reg, idw_step and the top-level framer.
`default_nettype none

package idw_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_BYTE - 1);

	// request modes
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_CMD  = 2'd1;
	localparam logic [1:0] MODE_DATA = 2'd2;

	// configuration register indexes
	localparam logic REG_DEV_ADDR    = 1'b0;
	localparam logic REG_RETRY_LIMIT = 1'b1;

	localparam logic [7:0]  DEV_ADDR_RST    = 8'h78;
	localparam logic [11:0] RETRY_LIMIT_RST = 12'd2500;
	localparam logic [7:0]  CTRL_CMD        = 8'h00;
	localparam logic [7:0]  CTRL_DATA       = 8'h40;

	// frame byte order
	localparam logic [1:0] BYTE_ADDR    = 2'd0;
	localparam logic [1:0] BYTE_CTRL    = 2'd1;
	localparam logic [1:0] BYTE_PAYLOAD = 2'd2;

	typedef enum logic [15:0] {
		PH_IDLE       = 16'h0001,
		PH_START_A    = 16'h0002,
		PH_START_B    = 16'h0004,
		PH_START_C    = 16'h0008,
		PH_BIT_LOW    = 16'h0010,
		PH_BIT_SET    = 16'h0020,
		PH_BIT_HIGH   = 16'h0040,
		PH_ACK_LOW    = 16'h0080,
		PH_ACK_REL    = 16'h0100,
		PH_ACK_HIGH   = 16'h0200,
		PH_ACK_SAMPLE = 16'h0400,
		PH_ACK_RETRY  = 16'h0800,
		PH_ACK_NEXT   = 16'h1000,
		PH_STOP_A     = 16'h2000,
		PH_STOP_B     = 16'h4000,
		PH_STOP_C     = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] payload;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		phase_t                phase;
		logic [BIT_CNT_W-1:0]  bit_count;
		logic [1:0]            byte_index;
		logic [7:0]            shift_byte;
		logic [7:0]            held_payload;
		logic                  is_data;
		logic [11:0]           retry_count;
		logic                  scl;
		logic                  sda;
		logic                  drv;
	} state_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
		logic ack_sampled;
		logic ack_timeout;
		logic busy;
		logic frame_done;
	} res_t;

	localparam state_t STATE_RST = '{
		phase:        PH_IDLE,
		bit_count:    '0,
		byte_index:   2'd0,
		shift_byte:   8'd0,
		held_payload: 8'd0,
		is_data:      1'b0,
		retry_count:  12'd0,
		scl:          1'b1,
		sda:          1'b1,
		drv:          1'b1
	};

endpackage

`default_nettype wire

@@ rtl/core/idw_in_reg.sv @@
// Input register stage of the framer: holds one accepted request.
// Depends on idw_pkg.
`default_nettype none

module idw_in_reg
	import idw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire item_t in_item,
	input  wire logic  drain,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic load;

	assign in_stall = valid_s1 && !drain;
	assign load     = !valid_s1 || drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/idw_step.sv @@
// Next-state and result logic of the framer: one bus phase per tick.
// Depends on idw_pkg.
`default_nettype none

module idw_step
	import idw_pkg::*;
(
	input  wire item_t       item,
	input  wire state_t      cur,
	input  wire logic [7:0]  dev_addr,
	input  wire logic [11:0] retry_limit,
	output state_t           nxt,
	output res_t             res
);

	always_comb begin
		nxt              = cur;
		res.ack_sampled  = 1'b0;
		res.ack_timeout  = 1'b0;
		res.frame_done   = 1'b0;

		if (item.mode inside {MODE_CMD, MODE_DATA}) begin
			if (cur.phase == PH_IDLE) begin
				nxt.held_payload = item.payload;
				nxt.is_data      = (item.mode == MODE_DATA);
				nxt.byte_index   = BYTE_ADDR;
				nxt.bit_count    = '0;
				nxt.retry_count  = 12'd0;
				nxt.phase        = PH_START_A;
			end
		end else if (item.mode == MODE_TICK) begin
			case (cur.phase)
				PH_IDLE: begin
				end
				PH_START_A: begin
					nxt.drv   = 1'b1;
					nxt.scl   = 1'b1;
					nxt.sda   = 1'b1;
					nxt.phase = PH_START_B;
				end
				PH_START_B: begin
					nxt.sda   = 1'b0;
					nxt.phase = PH_START_C;
				end
				PH_START_C: begin
					nxt.scl         = 1'b0;
					nxt.byte_index  = BYTE_ADDR;
					nxt.shift_byte  = dev_addr;
					nxt.bit_count   = '0;
					nxt.retry_count = 12'd0;
					nxt.phase       = PH_BIT_LOW;
				end
				PH_BIT_LOW: begin
					nxt.drv   = 1'b1;
					nxt.scl   = 1'b0;
					nxt.phase = PH_BIT_SET;
				end
				PH_BIT_SET: begin
					nxt.sda        = cur.shift_byte[7];
					nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
					nxt.phase      = PH_BIT_HIGH;
				end
				PH_BIT_HIGH: begin
					nxt.scl = 1'b1;
					if (cur.bit_count >= LAST_BIT) begin
						nxt.bit_count = '0;
						nxt.phase     = PH_ACK_LOW;
					end else begin
						nxt.bit_count = cur.bit_count + BIT_CNT_W'(1);
						nxt.phase     = PH_BIT_LOW;
					end
				end
				PH_ACK_LOW: begin
					nxt.scl   = 1'b0;
					nxt.phase = PH_ACK_REL;
				end
				PH_ACK_REL: begin
					nxt.sda   = 1'b1;
					nxt.phase = PH_ACK_HIGH;
				end
				PH_ACK_HIGH: begin
					nxt.scl   = 1'b1;
					nxt.phase = PH_ACK_SAMPLE;
				end
				PH_ACK_SAMPLE: begin
					nxt.drv         = 1'b0;
					res.ack_sampled = 1'b1;
					if (item.sda_in && (cur.retry_count < retry_limit)) begin
						nxt.retry_count = cur.retry_count + 12'd1;
						nxt.phase       = PH_ACK_RETRY;
					end else begin
						res.ack_timeout = item.sda_in;
						nxt.phase       = PH_ACK_NEXT;
					end
				end
				PH_ACK_RETRY: begin
					nxt.drv   = 1'b1;
					nxt.scl   = 1'b0;
					nxt.phase = PH_ACK_LOW;
				end
				PH_ACK_NEXT: begin
					nxt.drv = 1'b1;
					nxt.scl = 1'b0;
					// advance to the control byte, then the payload, then STOP
					if (cur.byte_index == BYTE_ADDR) begin
						nxt.byte_index  = BYTE_CTRL;
						nxt.shift_byte  = cur.is_data ? CTRL_DATA : CTRL_CMD;
						nxt.bit_count   = '0;
						nxt.retry_count = 12'd0;
						nxt.phase       = PH_BIT_LOW;
					end else if (cur.byte_index == BYTE_CTRL) begin
						nxt.byte_index  = BYTE_PAYLOAD;
						nxt.shift_byte  = cur.held_payload;
						nxt.bit_count   = '0;
						nxt.retry_count = 12'd0;
						nxt.phase       = PH_BIT_LOW;
					end else begin
						nxt.byte_index = BYTE_ADDR;
						nxt.phase      = PH_STOP_A;
					end
				end
				PH_STOP_A: begin
					nxt.drv   = 1'b1;
					nxt.sda   = 1'b0;
					nxt.phase = PH_STOP_B;
				end
				PH_STOP_B: begin
					nxt.scl   = 1'b1;
					nxt.phase = PH_STOP_C;
				end
				PH_STOP_C: begin
					nxt.sda        = 1'b1;
					res.frame_done = 1'b1;
					nxt.phase      = PH_IDLE;
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end

		res.scl  = nxt.scl;
		res.sda  = nxt.sda;
		res.drv  = nxt.drv;
		res.busy = (nxt.phase != PH_IDLE);
	end

endmodule

`default_nettype wire

@@ rtl/core/i2c_display_write_framer.sv @@
// A request is held in the input register (idw_in_reg), then its result in the result register res_q.
// Throughput: one request per cycle while out_stall is low; the input register and the result register
// let a new request enter while a finished result waits to be taken.
// Reset (arst_n low, asynchronous): idle state with SCL and SDA held high and driven,
// device address 0x78, ack retry limit 2500, no result pending.
// Top level of the I2C display write framer; depends on idw_pkg, idw_in_reg, idw_step.
`default_nettype none

module i2c_display_write_framer
	import idw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  payload,
	input  wire logic        sda_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             scl_level,
	output logic             sda_level,
	output logic             sda_drive,
	output logic             ack_sampled,
	output logic             ack_timeout,
	output logic             busy_res,
	output logic             frame_done
);

	logic        dev_addr_q;
	logic [7:0]  dev_addr_bits_q;
	logic [11:0] retry_limit_q;
	logic        valid_s1;
	item_t       item_s1;
	item_t       in_item;
	logic        drain;
	state_t      state_q;
	state_t      state_nxt;
	res_t        res;
	res_t        res_q;
	logic        out_valid_q;

	assign in_item = '{mode: mode, payload: payload, sda_in: sda_in};

	// consume the held request when the result register is free or being emptied
	assign drain = valid_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q      <= 1'b0;
			dev_addr_bits_q <= DEV_ADDR_RST;
			retry_limit_q   <= RETRY_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_DEV_ADDR: begin
					dev_addr_q      <= 1'b1;
					dev_addr_bits_q <= cfg_data[7:0];
				end
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	idw_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.drain    (drain),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	idw_step u_step (
		.item        (item_s1),
		.cur         (state_q),
		.dev_addr    (dev_addr_q ? dev_addr_bits_q : DEV_ADDR_RST),
		.retry_limit (retry_limit_q),
		.nxt         (state_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			out_valid_q <= 1'b0;
		end else if (drain) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign scl_level   = res_q.scl;
	assign sda_level   = res_q.sda;
	assign sda_drive   = res_q.drv;
	assign ack_sampled = res_q.ack_sampled;
	assign ack_timeout = res_q.ack_timeout;
	assign busy_res    = res_q.busy;
	assign frame_done  = res_q.frame_done;

endmodule

`default_nettype wire

@@ rtl/core/idw_checker.sv @@
// Port-level checker for the I2C display write framer, bound to the top level.
// Depends on assert_macros.svh and i2c_display_write_framer.
`default_nettype none
`include "assert_macros.svh"

module idw_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic scl_level,
	input wire logic sda_level,
	input wire logic sda_drive,
	input wire logic ack_sampled,
	input wire logic ack_timeout,
	input wire logic busy_res,
	input wire logic frame_done
);

	`ASSERT_IMP(a_done_not_busy, clk, arst_n, out_valid && frame_done, !busy_res)
	`ASSERT_IMP(a_timeout_sampled, clk, arst_n, out_valid && ack_timeout, ack_sampled)
	`ASSERT_IMP(a_sample_released, clk, arst_n, out_valid && ack_sampled, !sda_drive && scl_level)
	`ASSERT_IMP(a_stop_lines, clk, arst_n, out_valid && frame_done, scl_level && sda_level && sda_drive)
	`ASSERT_NXT(a_stall_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(scl_level) && $stable(sda_level) && $stable(sda_drive) && $stable(frame_done))

endmodule

bind i2c_display_write_framer idw_checker u_idw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.scl_level   (scl_level),
	.sda_level   (sda_level),
	.sda_drive   (sda_drive),
	.ack_sampled (ack_sampled),
	.ack_timeout (ack_timeout),
	.busy_res    (busy_res),
	.frame_done  (frame_done)
);

`default_nettype wire
